// ===== hdl/tucs_pkg.sv =====
`timescale 1ns / 1ps

package tucs_pkg;

  localparam int MAX_FRAME = 2048;
  localparam int POS_W     = $clog2(MAX_FRAME + 1);
  localparam int SUM_W     = $clog2(MAX_FRAME) + 17;
  localparam int LEN_W     = 17;
  localparam int OFF_W     = 5;

  localparam int ETH_HDR_LEN   = 14;
  localparam int VER_IHL_POS   = 14;
  localparam int TOT_LEN_HI    = 16;
  localparam int TOT_LEN_LO    = 17;
  localparam int PROTO_POS     = 23;
  localparam int ADDR_FIRST    = 26;
  localparam int ADDR_END      = 34;
  localparam int MIN_IPV4_HDR  = 20;
  localparam int MIN_IHL       = 5;
  localparam int MIN_FOR_VER   = 15;
  localparam int MIN_FOR_PROTO = 24;

  localparam logic [3:0] IPV4_VERSION = 4'h4;
  localparam logic [7:0] TCP_PROTOCOL = 8'd6;
  localparam logic [7:0] UDP_PROTOCOL = 8'd17;
  localparam logic [OFF_W-1:0] TCP_CSUM_OFF = OFF_W'(16);
  localparam logic [OFF_W-1:0] UDP_CSUM_OFF = OFF_W'(6);

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOT_IPV4 = 3'd1,
    ST_NOT_L4   = 3'd2,
    ST_L4_SHORT = 3'd3,
    ST_TRUNC    = 3'd4
  } status_t;

  typedef struct packed {
    status_t          status;
    logic [SUM_W-1:0] sum;
    logic [LEN_W-1:0] extra;
    logic [10:0]      position;
  } csum_job_t;

  function automatic logic [OFF_W-1:0] field_offset(input logic [7:0] proto);
    logic [OFF_W-1:0] off;
    case (proto)
      TCP_PROTOCOL: off = TCP_CSUM_OFF;
      UDP_PROTOCOL: off = UDP_CSUM_OFF;
      default:      off = '0;
    endcase
    return off;
  endfunction

endpackage

// ===== hdl/tucs_frame_track.sv =====
`timescale 1ns / 1ps

module tucs_frame_track (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output logic                in_ready,
  output logic                job_valid,
  input  logic                job_ready,
  output tucs_pkg::csum_job_t job
);

  logic [tucs_pkg::POS_W-1:0] byte_position;
  logic [5:0]                 header_length;
  logic [15:0]                total_length;
  logic [7:0]                 protocol_number;
  logic [tucs_pkg::SUM_W-1:0] running_sum;
  logic                       overflow_seen;

  logic [tucs_pkg::POS_W-1:0] n_count;
  logic [5:0]                 hl_next;
  logic [15:0]                tl_next;
  logic [7:0]                 proto_next;
  logic [tucs_pkg::SUM_W-1:0] sum_next;
  logic                       ovf_next;
  logic                       ovf_hit;
  logic                       take;
  logic [15:0]                word;
  logic                       addr_hit;
  logic                       l4_hit;
  logic [tucs_pkg::OFF_W-1:0] off_cur;
  logic [tucs_pkg::OFF_W-1:0] off_next;
  logic [tucs_pkg::LEN_W-1:0] p_ext;
  logic [tucs_pkg::LEN_W-1:0] l4_start;
  logic [tucs_pkg::LEN_W-1:0] l4_end;
  logic [tucs_pkg::LEN_W-1:0] cpos;
  logic [tucs_pkg::LEN_W-1:0] l4_len_next;
  logic [tucs_pkg::LEN_W-1:0] frame_end_next;
  tucs_pkg::csum_job_t        job_next;

  assign in_ready = !in_last || !job_valid || job_ready;

  always_comb begin
    ovf_hit = (byte_position == tucs_pkg::POS_W'(tucs_pkg::MAX_FRAME));
    take    = !ovf_hit;
    n_count = take ? byte_position + 1'b1 : byte_position;
    ovf_next = overflow_seen || ovf_hit;

    hl_next    = header_length;
    tl_next    = total_length;
    proto_next = protocol_number;
    if (take && byte_position == tucs_pkg::POS_W'(tucs_pkg::VER_IHL_POS)) begin
      hl_next = (in_byte[7:4] == tucs_pkg::IPV4_VERSION &&
                 in_byte[3:0] >= 4'(tucs_pkg::MIN_IHL)) ? {in_byte[3:0], 2'b00} : 6'd0;
    end
    if (take && byte_position == tucs_pkg::POS_W'(tucs_pkg::TOT_LEN_HI)) begin
      tl_next = {in_byte, total_length[7:0]};
    end
    if (take && byte_position == tucs_pkg::POS_W'(tucs_pkg::TOT_LEN_LO)) begin
      tl_next = {total_length[15:8], in_byte};
    end
    if (take && byte_position == tucs_pkg::POS_W'(tucs_pkg::PROTO_POS)) begin
      proto_next = in_byte;
    end

    word = byte_position[0] ? {8'h00, in_byte} : {in_byte, 8'h00};

    addr_hit = take && byte_position >= tucs_pkg::POS_W'(tucs_pkg::ADDR_FIRST) &&
               byte_position < tucs_pkg::POS_W'(tucs_pkg::ADDR_END);

    off_cur  = tucs_pkg::field_offset(protocol_number);
    p_ext    = tucs_pkg::LEN_W'(byte_position);
    l4_start = tucs_pkg::LEN_W'(tucs_pkg::ETH_HDR_LEN) + tucs_pkg::LEN_W'(header_length);
    l4_end   = tucs_pkg::LEN_W'(tucs_pkg::ETH_HDR_LEN) + tucs_pkg::LEN_W'(total_length);
    cpos     = l4_start + tucs_pkg::LEN_W'(off_cur);
    l4_hit   = take && header_length >= 6'(tucs_pkg::MIN_IPV4_HDR) &&
               p_ext >= l4_start && p_ext < l4_end &&
               !(off_cur != '0 && (p_ext == cpos || p_ext == cpos + 1'b1));

    sum_next = running_sum + ((addr_hit || l4_hit) ? tucs_pkg::SUM_W'(word) : '0);

    off_next       = tucs_pkg::field_offset(proto_next);
    l4_len_next    = {1'b0, tl_next} - tucs_pkg::LEN_W'(hl_next);
    frame_end_next = tucs_pkg::LEN_W'(tucs_pkg::ETH_HDR_LEN) + tucs_pkg::LEN_W'(tl_next);

    job_next.sum      = sum_next;
    job_next.extra    = tucs_pkg::LEN_W'(proto_next) + tucs_pkg::LEN_W'(l4_len_next[15:0]);
    job_next.position = '0;
    if (ovf_next || n_count < tucs_pkg::POS_W'(tucs_pkg::MIN_FOR_VER)) begin
      job_next.status = tucs_pkg::ST_TRUNC;
    end else if (hl_next == 6'd0) begin
      job_next.status = tucs_pkg::ST_NOT_IPV4;
    end else if (n_count < tucs_pkg::POS_W'(tucs_pkg::MIN_FOR_PROTO)) begin
      job_next.status = tucs_pkg::ST_TRUNC;
    end else if (off_next == '0) begin
      job_next.status = tucs_pkg::ST_NOT_L4;
    end else if (l4_len_next[16] ||
                 l4_len_next[15:0] < 16'(off_next) + 16'd2) begin
      job_next.status = tucs_pkg::ST_L4_SHORT;
    end else if (tucs_pkg::LEN_W'(n_count) < frame_end_next) begin
      job_next.status = tucs_pkg::ST_TRUNC;
    end else begin
      job_next.status   = tucs_pkg::ST_OK;
      job_next.position = 11'(tucs_pkg::ETH_HDR_LEN) + 11'(hl_next) + 11'(off_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      header_length   <= '0;
      total_length    <= '0;
      protocol_number <= '0;
      running_sum     <= '0;
      overflow_seen   <= 1'b0;
      job_valid       <= 1'b0;
    end else begin
      if (in_valid && in_ready && in_last) begin
        job_valid <= 1'b1;
      end else if (job_valid && job_ready) begin
        job_valid <= 1'b0;
      end
      if (in_valid && in_ready) begin
        if (in_last) begin
          byte_position   <= '0;
          header_length   <= '0;
          total_length    <= '0;
          protocol_number <= '0;
          running_sum     <= '0;
          overflow_seen   <= 1'b0;
          job             <= job_next;
        end else begin
          byte_position   <= n_count;
          header_length   <= hl_next;
          total_length    <= tl_next;
          protocol_number <= proto_next;
          running_sum     <= sum_next;
          overflow_seen   <= ovf_next;
        end
      end
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    byte_position <= tucs_pkg::POS_W'(tucs_pkg::MAX_FRAME))
    else $error("byte count past frame limit");

  a_ovf_at_limit: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> byte_position == tucs_pkg::POS_W'(tucs_pkg::MAX_FRAME))
    else $error("overflow flag without full count");

  a_job_hold: assert property (@(posedge clk) disable iff (rst)
    job_valid && !job_ready |=> job_valid && $stable(job))
    else $error("pending result changed");

  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    job_valid && job.status != tucs_pkg::ST_OK |-> job.position == 11'd0)
    else $error("position set on failed frame");

endmodule

// ===== hdl/tucs_csum_fold.sv =====
`timescale 1ns / 1ps

module tucs_csum_fold (
  input  logic [tucs_pkg::SUM_W-1:0] sum,
  input  logic [tucs_pkg::LEN_W-1:0] extra,
  output logic [15:0]                checksum
);

  logic [tucs_pkg::SUM_W:0] total;
  logic [16:0]              fold1;
  logic [16:0]              fold2;

  always_comb begin
    total    = {1'b0, sum} + (tucs_pkg::SUM_W + 1)'(extra);
    fold1    = 17'(total[15:0]) + 17'(total[tucs_pkg::SUM_W:16]);
    fold2    = 17'(fold1[15:0]) + 17'(fold1[16]);
    checksum = ~fold2[15:0];
  end

endmodule

// ===== hdl/tcp_udp_checksum_insert.sv =====
`timescale 1ns / 1ps
// Input register, tracker job register, then output register lie between last byte and result.
// Throughput: one frame byte per cycle, including across frame boundaries, while results are taken.
// One result per frame, held in an output register while the next frame streams in.
// Reset (rst, synchronous, active high) clears frame state and all valid flags.

module tcp_udp_checksum_insert (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [2:0] status, [18:3] checksum_value, [29:19] checksum_position
);

  logic                in_valid;
  logic [7:0]          in_byte;
  logic                in_last;
  logic                in_ready;
  logic                job_valid;
  logic                job_ready;
  tucs_pkg::csum_job_t job;
  logic [15:0]         checksum;
  logic [2:0]          out_status;
  logic [15:0]         out_value;
  logic [10:0]         out_position;

  assign s_axis_tready = !in_valid || in_ready;
  assign job_ready     = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata  = {2'b00, out_position, out_value, out_status};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  tucs_frame_track u_track (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .in_ready  (in_ready),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  tucs_csum_fold u_fold (
    .sum      (job.sum),
    .extra    (job.extra),
    .checksum (checksum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (job_ready) begin
      m_axis_tvalid <= job_valid;
    end
    if (job_ready && job_valid) begin
      out_status   <= job.status;
      out_value    <= (job.status == tucs_pkg::ST_OK) ? checksum : 16'd0;
      out_position <= job.position;
    end
  end

endmodule

// ===== tb/sv/tcp_udp_checksum_insert_tb.sv =====
`timescale 1ns / 1ps

module tcp_udp_checksum_insert_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int QUIET_TAIL  = 120;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         drain;
  } frame_beat_t;

  typedef struct packed {
    tucs_pkg::status_t status;
    logic [15:0]       value;
    logic [10:0]       position;
  } csum_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  frame_beat_t  pending[$];
  csum_result_t csum_expected[$];

  // running state of the frame being summed
  int unsigned  fr_count;
  int unsigned  fr_hdr_len;
  logic [15:0]  fr_ip_len;
  logic [7:0]   fr_proto;
  logic [31:0]  fr_sum;
  bit           fr_over;

  bit          byte_taken;
  int          src_gap;
  int          snk_gap;
  bit          src_calm;
  bit          snk_calm;
  int          idle_cycles;
  int          errors;
  int          bytes_total;
  int          bytes_taken;
  int          frames_queued;
  int          results_checked;
  int          status_hits[5];

  tcp_udp_checksum_insert u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned csum_field_offset(input logic [7:0] proto);
    if (proto == tucs_pkg::TCP_PROTOCOL) begin
      return tucs_pkg::TCP_CSUM_OFF;
    end else if (proto == tucs_pkg::UDP_PROTOCOL) begin
      return tucs_pkg::UDP_CSUM_OFF;
    end
    return 0;
  endfunction

  function automatic void clear_frame();
    fr_count   = 0;
    fr_hdr_len = 0;
    fr_ip_len  = '0;
    fr_proto   = '0;
    fr_sum     = '0;
    fr_over    = 1'b0;
  endfunction

  // add one transferred byte to the frame state; on the last byte, push the result
  task automatic ingest_byte(input logic [7:0] b, input logic last);
    int unsigned  p;
    int unsigned  off;
    int unsigned  cpos;
    logic [31:0]  word;
    logic [31:0]  s;
    csum_result_t r;
    if (fr_count >= tucs_pkg::MAX_FRAME) begin
      fr_over = 1'b1;
    end else begin
      p = fr_count;
      word = p[0] ? {24'd0, b} : {16'd0, b, 8'd0};
      if (p == tucs_pkg::VER_IHL_POS) begin
        fr_hdr_len = (b[7:4] == tucs_pkg::IPV4_VERSION && b[3:0] >= tucs_pkg::MIN_IHL) ?
                     int'(b[3:0]) * 4 : 0;
      end else if (p == tucs_pkg::TOT_LEN_HI) begin
        fr_ip_len[15:8] = b;
      end else if (p == tucs_pkg::TOT_LEN_LO) begin
        fr_ip_len[7:0] = b;
      end else if (p == tucs_pkg::PROTO_POS) begin
        fr_proto = b;
      end
      if (p >= tucs_pkg::ADDR_FIRST && p < tucs_pkg::ADDR_END) begin
        fr_sum += word;
      end
      if (fr_hdr_len >= tucs_pkg::MIN_IPV4_HDR && p >= tucs_pkg::ETH_HDR_LEN + fr_hdr_len &&
          p < tucs_pkg::ETH_HDR_LEN + fr_ip_len) begin
        off  = csum_field_offset(fr_proto);
        cpos = tucs_pkg::ETH_HDR_LEN + fr_hdr_len + off;
        if (off == 0 || (p != cpos && p != cpos + 1)) begin
          fr_sum += word;
        end
      end
      fr_count++;
    end
    if (last) begin
      off = csum_field_offset(fr_proto);
      r.value    = '0;
      r.position = '0;
      if (fr_over || fr_count < tucs_pkg::MIN_FOR_VER) begin
        r.status = tucs_pkg::ST_TRUNC;
      end else if (fr_hdr_len == 0) begin
        r.status = tucs_pkg::ST_NOT_IPV4;
      end else if (fr_count < tucs_pkg::MIN_FOR_PROTO) begin
        r.status = tucs_pkg::ST_TRUNC;
      end else if (off == 0) begin
        r.status = tucs_pkg::ST_NOT_L4;
      end else if (fr_ip_len < fr_hdr_len || fr_ip_len - fr_hdr_len < off + 2) begin
        r.status = tucs_pkg::ST_L4_SHORT;
      end else if (fr_count < tucs_pkg::ETH_HDR_LEN + fr_ip_len) begin
        r.status = tucs_pkg::ST_TRUNC;
      end else begin
        s = fr_sum + fr_proto + (fr_ip_len - fr_hdr_len);
        while (s[31:16] != 0) begin
          s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
        end
        r.status   = tucs_pkg::ST_OK;
        r.value    = ~s[15:0];
        r.position = 11'(tucs_pkg::ETH_HDR_LEN + fr_hdr_len + off);
      end
      csum_expected.push_back(r);
      clear_frame();
    end
  endtask

  task automatic queue_frame(input logic [7:0] ver_ihl, input logic [15:0] ip_len,
                             input logic [7:0] proto, input int nbytes, input int fill,
                             input bit drain);
    frame_beat_t bt;
    int          i;
    for (i = 0; i < nbytes; i++) begin
      bt.data = (fill < 0) ? 8'($urandom) : 8'(fill);
      if (i == tucs_pkg::VER_IHL_POS) begin
        bt.data = ver_ihl;
      end else if (i == tucs_pkg::TOT_LEN_HI) begin
        bt.data = ip_len[15:8];
      end else if (i == tucs_pkg::TOT_LEN_LO) begin
        bt.data = ip_len[7:0];
      end else if (i == tucs_pkg::PROTO_POS) begin
        bt.data = proto;
      end
      bt.last  = (i == nbytes - 1);
      bt.drain = drain && (i == 0);
      pending.push_back(bt);
    end
    frames_queued++;
  endtask

  // IPv4 frame with the given L4 length; slack pads (>0) or cuts (<0) the frame
  task automatic queue_l4(input int ihl, input logic [7:0] proto, input int l4_len,
                          input int slack, input int fill, input bit drain);
    int ip_len;
    int nbytes;
    ip_len = ihl * 4 + l4_len;
    nbytes = tucs_pkg::ETH_HDR_LEN + ip_len + slack;
    if (nbytes < 1) begin
      nbytes = 1;
    end
    queue_frame({tucs_pkg::IPV4_VERSION, 4'(ihl)}, 16'(ip_len), proto, nbytes, fill, drain);
  endtask

  // sender
  always @(negedge clk) begin : drive_frame_bytes
    frame_beat_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || byte_taken) begin
      if ($urandom_range(0, 99) == 0) begin
        src_calm = !src_calm;
      end
      if (src_gap != 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending.size() == 0 ||
                   (pending[0].drain && csum_expected.size() != 0)) begin
        s_axis_tvalid <= 1'b0;
      end else if (pending.size() >= QUIET_TAIL && !src_calm &&
                   $urandom_range(0, 5) == 0) begin
        src_gap = $urandom_range(1, 5) - 1;
        s_axis_tvalid <= 1'b0;
      end else begin
        nxt = pending.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.data;
        s_axis_tlast  <= nxt.last;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) == 0) begin
        snk_calm = !snk_calm;
      end
      if (snk_gap != 0) begin
        snk_gap--;
        m_axis_tready <= 1'b0;
      end else if (pending.size() >= QUIET_TAIL && !snk_calm &&
                   $urandom_range(0, 4) == 0) begin
        snk_gap = $urandom_range(1, 5) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // predict on input transfers, compare output transfers, watchdog
  always @(posedge clk) begin : check_results
    csum_result_t want;
    logic [2:0]   got_status;
    logic [15:0]  got_value;
    logic [10:0]  got_position;
    byte_taken = 1'b0;
    if (!rst) begin
      idle_cycles++;
      if (s_axis_tvalid && s_axis_tready) begin
        byte_taken = 1'b1;
        bytes_taken++;
        idle_cycles = 0;
        ingest_byte(s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        idle_cycles  = 0;
        got_status   = m_axis_tdata[2:0];
        got_value    = m_axis_tdata[18:3];
        got_position = m_axis_tdata[29:19];
        if (csum_expected.size() == 0) begin
          $display("%0t: result with none expected, actual %h", $time, m_axis_tdata);
          errors++;
        end else begin
          want = csum_expected.pop_front();
          results_checked++;
          if (want.status < 5) begin
            status_hits[want.status]++;
          end
          if (got_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got_status);
            errors++;
          end
          if (got_value !== want.value) begin
            $display("%0t: checksum expected %h actual %h", $time, want.value, got_value);
            errors++;
          end
          if (got_position !== want.position) begin
            $display("%0t: position expected %0d actual %0d", $time, want.position,
                     got_position);
            errors++;
          end
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("tcp_udp_checksum_insert test failed");
        $finish;
      end
    end
  end

  initial begin : run_test
    int          ihl;
    int          l4;
    int          slack;
    int          rand_frames;
    logic [7:0]  proto;
    clear_frame();

    queue_l4(5, tucs_pkg::TCP_PROTOCOL, 18, 0, -1, 1'b0);
    queue_l4(5, tucs_pkg::UDP_PROTOCOL, 8, 0, -1, 1'b0);
    queue_l4(5, tucs_pkg::UDP_PROTOCOL, 9, 0, -1, 1'b0);
    queue_l4(15, tucs_pkg::TCP_PROTOCOL, 40, 0, 8'hff, 1'b0);
    queue_l4(5, tucs_pkg::UDP_PROTOCOL, 8, 0, 8'h00, 1'b1);
    queue_frame(8'h65, 16'd40, tucs_pkg::TCP_PROTOCOL, 60, -1, 1'b0);
    queue_frame(8'h44, 16'd40, tucs_pkg::TCP_PROTOCOL, 60, -1, 1'b0);
    queue_frame(8'h40, 16'd40, tucs_pkg::UDP_PROTOCOL, 60, -1, 1'b0);
    queue_frame(8'h45, 16'd40, 8'd1, 54, -1, 1'b0);
    queue_l4(5, tucs_pkg::UDP_PROTOCOL, 7, 0, -1, 1'b0);
    queue_l4(5, tucs_pkg::TCP_PROTOCOL, 17, 0, -1, 1'b0);
    queue_frame(8'h45, 16'd10, tucs_pkg::TCP_PROTOCOL, 60, -1, 1'b0);
    queue_l4(5, tucs_pkg::TCP_PROTOCOL, 30, -5, -1, 1'b0);
    queue_l4(5, tucs_pkg::UDP_PROTOCOL, 10, 12, -1, 1'b0);
    queue_frame(8'h45, 16'd40, tucs_pkg::TCP_PROTOCOL, 1, -1, 1'b0);
    queue_frame(8'h45, 16'd40, tucs_pkg::TCP_PROTOCOL, 14, -1, 1'b0);
    queue_frame(8'h35, 16'd40, tucs_pkg::TCP_PROTOCOL, 15, -1, 1'b0);
    queue_frame(8'h45, 16'd40, tucs_pkg::TCP_PROTOCOL, 20, -1, 1'b0);
    queue_frame(8'h45, 16'd40, tucs_pkg::UDP_PROTOCOL, 23, -1, 1'b0);
    queue_frame(8'h45, 16'hffff, tucs_pkg::UDP_PROTOCOL, 80, -1, 1'b0);
    queue_l4(15, tucs_pkg::UDP_PROTOCOL, 8, 0, -1, 1'b1);

    // mostly well-formed TCP/UDP frames, some cut or padded, the rest noise
    rand_frames = 0;
    while (pending.size() < 1400 || rand_frames < 4) begin
      if ($urandom_range(0, 9) < 8) begin
        ihl   = ($urandom_range(0, 3) == 0) ? int'($urandom_range(5, 15)) : 5;
        proto = $urandom_range(0, 1) ? tucs_pkg::TCP_PROTOCOL : tucs_pkg::UDP_PROTOCOL;
        l4    = $urandom_range(csum_field_offset(proto) + 2, csum_field_offset(proto) + 40);
        case ($urandom_range(0, 5))
          0:       slack = -int'($urandom_range(1, l4));
          1:       slack = $urandom_range(1, 8);
          default: slack = 0;
        endcase
        queue_l4(ihl, proto, l4, slack, -1, $urandom_range(0, 39) == 0);
      end else begin
        proto = $urandom_range(0, 1) ? 8'($urandom) :
                ($urandom_range(0, 1) ? tucs_pkg::TCP_PROTOCOL : tucs_pkg::UDP_PROTOCOL);
        queue_frame(8'($urandom),
                    ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(20, 80)),
                    proto, $urandom_range(1, 90), -1, 1'b0);
      end
      rand_frames++;
    end
    bytes_total = pending.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (bytes_taken < bytes_total) @(posedge clk);
    while (csum_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d frames, %0d bytes, %0d results checked", frames_queued,
             bytes_taken, results_checked);
    $display("by status: ok %0d, not ipv4 %0d, not tcp/udp %0d, l4 short %0d, truncated %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
    if (errors == 0) begin
      $display("tcp_udp_checksum_insert test passed");
    end else begin
      $display("tcp_udp_checksum_insert test failed");
    end
    $finish;
  end

endmodule
